FILE: sv/bdi_pkg.sv
// package for the beta diversity index block: widths, snapshot and status types,
// sequencer codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdi_pkg;

  localparam int AB_W    = 24;   // abundance width
  localparam int OUT_W   = 17;   // index width
  localparam int CNT_W   = 17;   // bin class counters
  localparam int SUM_W   = 41;   // totals and sum of minima
  localparam int SQ_W    = 64;   // products and squares

  // wide arithmetic for morisita-horn, in 32-bit limbs
  localparam int LIMB_W  = 32;
  localparam int NLIMB   = 5;
  localparam int WIDE_W  = LIMB_W * NLIMB;
  localparam int LIMB_IW = 3;

  // snapshot queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam int MAX_BINS_DEF  = 65536;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic [CNT_W-1:0] shared_bins;
    logic [CNT_W-1:0] only_a_bins;
    logic [CNT_W-1:0] only_b_bins;
    logic [SUM_W-1:0] total_a;
    logic [SUM_W-1:0] total_b;
    logic [SUM_W-1:0] sum_of_minima;
    logic [SQ_W-1:0]  sum_of_products;
    logic [SQ_W-1:0]  squares_a;
    logic [SQ_W-1:0]  squares_b;
  } snap_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_MUL_END, ST_SUM, ST_DIV_LOAD, ST_DIV, ST_DIV_END, ST_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    OP_BB, OP_AA, OP_SA_BB, OP_SB_AA, OP_PA, OP_PAB
  } mul_op_t;

  typedef enum logic [1:0] {
    DV_WHIT, DV_JACC, DV_SOR, DV_MH
  } div_sel_t;

endpackage

`default_nettype wire

FILE: sv/bdi_if.sv
// valid/ready channel interfaces for bin pairs in and indices out
// depends on bdi_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bdi_in_if import bdi_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [AB_W-1:0] abundance_a;
  logic [AB_W-1:0] abundance_b;
  logic            last_bin;

  modport source (output valid, abundance_a, abundance_b, last_bin, input ready);
  modport sink   (input valid, abundance_a, abundance_b, last_bin, output ready);
endinterface

interface bdi_out_if import bdi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] whittaker_index;
  logic [OUT_W-1:0] jaccard_similarity;
  logic [OUT_W-1:0] sorensen_quantitative;
  logic [OUT_W-1:0] morisita_horn;

  modport source (output valid, whittaker_index, jaccard_similarity,
                  sorensen_quantitative, morisita_horn, input ready);
  modport sink   (input valid, whittaker_index, jaccard_similarity,
                  sorensen_quantitative, morisita_horn, output ready);
endinterface

`default_nettype wire

FILE: sv/bdi_front.sv
// front end: takes bin pairs, classifies them, squares and multiplies, accumulates
// and pushes a snapshot per vector; depends on bdi_pkg, bdi_if
`timescale 1ns / 1ps
`default_nettype none

module bdi_front import bdi_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  bdi_in_if.sink in_ch,
  input  qstat_t qstat,
  output logic   push,
  output snap_t  push_data
);

  localparam int BC_W = $clog2(MAX_BINS + 1);

  logic            xfer;
  logic            s1_valid, s1_last;
  logic [AB_W-1:0] s1_a, s1_b;

  logic              s2_valid, s2_last, s2_sh, s2_oa, s2_ob;
  logic [AB_W-1:0]   s2_a, s2_b, s2_min;
  logic [2*AB_W-1:0] s2_ab, s2_aa, s2_bb;

  logic [BC_W-1:0] bin_count;
  logic            take;
  snap_t           acc, acc_next;
  logic [QCNT_W:0] pending;

  // hold off while every queue slot is spoken for by stored or in-flight vectors
  assign pending = {1'b0, qstat.count} + (QCNT_W+1)'(s1_valid && s1_last)
                 + (QCNT_W+1)'(s2_valid && s2_last);
  assign in_ch.ready = pending < (QCNT_W+1)'(QDEPTH);
  assign xfer = in_ch.valid && in_ch.ready;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= xfer;
    end
    if (xfer) begin
      s1_a    <= in_ch.abundance_a;
      s1_b    <= in_ch.abundance_b;
      s1_last <= in_ch.last_bin;
    end
  end

  // stage 2: classify, minimum and products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_last <= s1_last;
    s2_a    <= s1_a;
    s2_b    <= s1_b;
    s2_min  <= (s1_a < s1_b) ? s1_a : s1_b;
    s2_sh   <= (s1_a != '0) && (s1_b != '0);
    s2_oa   <= (s1_a != '0) && (s1_b == '0);
    s2_ob   <= (s1_a == '0) && (s1_b != '0);
    s2_ab   <= (2*AB_W)'(s1_a) * (2*AB_W)'(s1_b);
    s2_aa   <= (2*AB_W)'(s1_a) * (2*AB_W)'(s1_a);
    s2_bb   <= (2*AB_W)'(s1_b) * (2*AB_W)'(s1_b);
  end

  // stage 3: accumulate, bins past the limit are dropped
  assign take = s2_valid && (bin_count < BC_W'(MAX_BINS));

  always_comb begin
    acc_next                 = acc;
    acc_next.shared_bins     = acc.shared_bins + CNT_W'(take && s2_sh);
    acc_next.only_a_bins     = acc.only_a_bins + CNT_W'(take && s2_oa);
    acc_next.only_b_bins     = acc.only_b_bins + CNT_W'(take && s2_ob);
    if (take) begin
      acc_next.total_a         = acc.total_a + SUM_W'(s2_a);
      acc_next.total_b         = acc.total_b + SUM_W'(s2_b);
      acc_next.sum_of_minima   = acc.sum_of_minima + SUM_W'(s2_min);
      acc_next.sum_of_products = acc.sum_of_products + SQ_W'(s2_ab);
      acc_next.squares_a       = acc.squares_a + SQ_W'(s2_aa);
      acc_next.squares_b       = acc.squares_b + SQ_W'(s2_bb);
    end
  end

  assign push      = s2_valid && s2_last;
  assign push_data = acc_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      acc       <= '0;
      bin_count <= '0;
    end else if (s2_valid) begin
      acc       <= acc_next;
      bin_count <= bin_count + BC_W'(take);
    end
  end

endmodule

`default_nettype wire

FILE: sv/bdi_queue.sv
// short snapshot queue between front and back
// depends on bdi_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdi_queue import bdi_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  snap_t  push_data,
  input  logic   pop,
  output snap_t  pop_data,
  output qstat_t qstat
);

  snap_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QCNT_W-1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

  assign pop_data    = slots[rp];
  assign qstat.empty = (count == '0);
  assign qstat.count = count;

endmodule

`default_nettype wire

FILE: sv/bdi_back.sv
// back end: limb-serial multiplier for morisita-horn terms, shared restoring divider
// for the four indices, output register; depends on bdi_pkg, bdi_if
`timescale 1ns / 1ps
`default_nettype none

module bdi_back import bdi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  qstat_t    qstat,
  input  snap_t     pop_data,
  output logic      pop,
  bdi_out_if.source out_ch
);

  localparam int QW   = FRAC_BITS + 1;
  localparam int DC_W = $clog2(FRAC_BITS);

  back_state_t state, state_next;
  snap_t       snap;
  mul_op_t     op;
  div_sel_t    dsel;

  logic [LIMB_IW-1:0]  li, lj;
  logic [2*LIMB_W-1:0] pp;
  logic [LIMB_IW:0]    pp_sh;
  logic                pp_valid;
  logic [WIDE_W-1:0]   acc, w0, w1, w2, pp_shifted, mx, my;
  logic [LIMB_W-1:0]   x_limb, y_limb;
  logic                mul_last;

  logic [WIDE_W-1:0] dnum, dden, dreg;
  logic [WIDE_W:0]   rem, rem2;
  logic [QW-1:0]     q;
  logic [DC_W-1:0]   dcnt;
  logic [CNT_W:0]    diff;
  logic [QW+OUT_W-1:0] qx;
  logic [OUT_W-1:0]  res [4];
  logic              out_valid, emit;
  logic [OUT_W-1:0]  o_whit, o_jacc, o_sor, o_mh;

  // multiplier operand select
  always_comb begin
    case (op)
      OP_BB:    begin mx = WIDE_W'(snap.total_b);         my = WIDE_W'(snap.total_b); end
      OP_AA:    begin mx = WIDE_W'(snap.total_a);         my = WIDE_W'(snap.total_a); end
      OP_SA_BB: begin mx = w0;                            my = WIDE_W'(snap.squares_a); end
      OP_SB_AA: begin mx = w1;                            my = WIDE_W'(snap.squares_b); end
      OP_PA:    begin mx = WIDE_W'(snap.sum_of_products); my = WIDE_W'(snap.total_a); end
      OP_PAB:   begin mx = w2;                            my = WIDE_W'(snap.total_b); end
      default:  begin mx = '0;                            my = '0; end
    endcase
  end

  assign x_limb     = mx[LIMB_W*li +: LIMB_W];
  assign y_limb     = my[LIMB_W*lj +: LIMB_W];
  assign pp_shifted = WIDE_W'(pp) << (LIMB_W * pp_sh);
  assign mul_last   = (li == LIMB_IW'(NLIMB-1)) && (lj == LIMB_IW'(NLIMB-1));

  // divider operand select
  assign diff = {1'b0, snap.only_a_bins} + {1'b0, snap.only_b_bins};
  always_comb begin
    case (dsel)
      DV_WHIT: begin
        dnum = WIDE_W'(diff);
        dden = WIDE_W'({snap.shared_bins, 1'b0}) + WIDE_W'(diff);
      end
      DV_JACC: begin
        dnum = WIDE_W'(snap.shared_bins);
        dden = WIDE_W'(snap.shared_bins) + WIDE_W'(diff);
      end
      DV_SOR: begin
        dnum = WIDE_W'({snap.sum_of_minima, 1'b0});
        dden = WIDE_W'(snap.total_a) + WIDE_W'(snap.total_b);
      end
      DV_MH: begin
        dnum = {w2[WIDE_W-2:0], 1'b0};
        dden = w0;
      end
      default: begin
        dnum = '0;
        dden = '0;
      end
    endcase
  end

  assign rem2 = {rem[WIDE_W-1:0], 1'b0};
  assign qx   = {{OUT_W{1'b0}}, q};
  assign emit = (state == ST_EMIT) && (!out_valid || out_ch.ready);
  assign pop  = (state == ST_IDLE) && !qstat.empty;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (!qstat.empty) state_next = ST_MUL;
      ST_MUL:      if (mul_last) state_next = ST_MUL_END;
      ST_MUL_END: begin
        if (op == OP_SB_AA) state_next = ST_SUM;
        else if (op == OP_PAB) state_next = ST_DIV_LOAD;
        else state_next = ST_MUL;
      end
      ST_SUM:      state_next = ST_MUL;
      ST_DIV_LOAD: begin
        if (dden == '0 || dnum >= dden) state_next = ST_DIV_END;
        else state_next = ST_DIV;
      end
      ST_DIV:      if (dcnt == DC_W'(FRAC_BITS-1)) state_next = ST_DIV_END;
      ST_DIV_END:  state_next = (dsel == DV_MH) ? ST_EMIT : ST_DIV_LOAD;
      ST_EMIT:     if (emit) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        snap     <= pop_data;
        op       <= OP_BB;
        li       <= '0;
        lj       <= '0;
        acc      <= '0;
        pp_valid <= 1'b0;
      end
      ST_MUL: begin
        pp       <= (2*LIMB_W)'(x_limb) * (2*LIMB_W)'(y_limb);
        pp_sh    <= (LIMB_IW+1)'(li) + (LIMB_IW+1)'(lj);
        pp_valid <= 1'b1;
        if (pp_valid) acc <= acc + pp_shifted;
        if (lj == LIMB_IW'(NLIMB-1)) begin
          lj <= '0;
          li <= li + 1'b1;
        end else begin
          lj <= lj + 1'b1;
        end
      end
      ST_MUL_END: begin
        case (op)
          OP_BB, OP_SA_BB: w0 <= acc + pp_shifted;
          OP_AA, OP_SB_AA: w1 <= acc + pp_shifted;
          default:         w2 <= acc + pp_shifted;
        endcase
        case (op)
          OP_BB:    op <= OP_AA;
          OP_AA:    op <= OP_SA_BB;
          OP_SA_BB: op <= OP_SB_AA;
          OP_SB_AA: op <= OP_PA;
          OP_PA:    op <= OP_PAB;
          default:  op <= OP_PAB;
        endcase
        li       <= '0;
        lj       <= '0;
        acc      <= '0;
        pp_valid <= 1'b0;
        dsel     <= DV_WHIT;
      end
      ST_SUM: begin
        w0 <= w0 + w1;
      end
      ST_DIV_LOAD: begin
        dcnt <= '0;
        rem  <= {1'b0, dnum};
        dreg <= dden;
        if (dden == '0) q <= '0;
        else if (dnum >= dden) q <= QW'(1) << FRAC_BITS;
        else q <= '0;
      end
      ST_DIV: begin
        dcnt <= dcnt + 1'b1;
        if (rem2 >= {1'b0, dreg}) begin
          rem <= rem2 - {1'b0, dreg};
          q   <= {q[QW-2:0], 1'b1};
        end else begin
          rem <= rem2;
          q   <= {q[QW-2:0], 1'b0};
        end
      end
      ST_DIV_END: begin
        res[dsel] <= qx[OUT_W-1:0];
        case (dsel)
          DV_WHIT: dsel <= DV_JACC;
          DV_JACC: dsel <= DV_SOR;
          DV_SOR:  dsel <= DV_MH;
          default: dsel <= DV_MH;
        endcase
      end
      ST_EMIT: begin
        if (emit) begin
          o_whit <= res[0];
          o_jacc <= res[1];
          o_sor  <= res[2];
          o_mh   <= res[3];
        end
      end
      default: begin
      end
    endcase
  end

  // output register, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid                 = out_valid;
  assign out_ch.whittaker_index       = o_whit;
  assign out_ch.jaccard_similarity    = o_jacc;
  assign out_ch.sorensen_quantitative = o_sor;
  assign out_ch.morisita_horn         = o_mh;

endmodule

`default_nettype wire

FILE: sv/beta_diversity_indices.sv
// top level of the beta diversity index block: front, snapshot queue, back
// depends on bdi_pkg, bdi_if, bdi_front, bdi_queue, bdi_back
`timescale 1ns / 1ps
`default_nettype none

// Streams one bin pair per cycle (abundance_a, abundance_b, last_bin) while the input
// is not stalled and, after the bin flagged last, returns Whittaker, Jaccard-type,
// quantitative Sorensen and Morisita-Horn indices as unsigned fixed point with
// FRAC_BITS fraction bits, 0 when a divisor is zero. Bins beyond MAX_BINS in a vector
// are ignored. The front end takes a bin every cycle unless stalled, through a
// three-stage pipeline, and hands each finished vector to a four-entry snapshot queue.
// The back end takes one vector at a time from the queue: six wide products on a
// single 32x32 multiplier, one limb pair per cycle, then four divisions on one
// restoring divider, one quotient bit per cycle. Input stalls only when stored and
// in-flight vectors fill the four queue slots; results wait in an output register.

module beta_diversity_indices import bdi_pkg::*; #(
  parameter int MAX_BINS  = MAX_BINS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bdi_in_if.sink    in_ch,
  bdi_out_if.source out_ch
);

  logic   push, pop;
  snap_t  push_data, pop_data;
  qstat_t qstat;

  bdi_front #(.MAX_BINS(MAX_BINS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  bdi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  bdi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // queue never pops empty or overfills
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("snapshot popped from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (qstat.count < QCNT_W'(QDEPTH)) || pop)
    else $error("snapshot pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("snapshot queue count out of range");

endmodule

`default_nettype wire
